// ----- hw/rtl/lsfh_pkg.sv -----
package lsfh_pkg;

  localparam int unsigned BufferBytes = 8;
  localparam int unsigned BufIdxW = $clog2(BufferBytes);

  // bus event codes
  localparam logic [1:0] ACT_BREAK   = 2'd0;
  localparam logic [1:0] ACT_BYTE    = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;

  // frame phase codes
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_SYNC    = 3'd1;
  localparam logic [2:0] PH_ID      = 3'd2;
  localparam logic [2:0] PH_RECEIVE = 3'd3;
  localparam logic [2:0] PH_SEND    = 3'd4;

  localparam logic [7:0] SYNC_BYTE = 8'h55;
  localparam logic [5:0] ID_COMMISSION = 6'd1;
  localparam logic [5:0] ID_ALL_SWITCHES = 6'd2;
  localparam logic [5:0] ID_DIAG = 6'h3c;
  localparam logic [5:0] ID_SWITCH_RESET = 6'd3;
  localparam logic [5:0] ID_RELAY_RESET = 6'd4;
  localparam logic [5:0] ID_MIN = 6'd4;
  localparam logic [31:0] NODE_IDENTITY_RESET = 32'h19f0743e;

  localparam logic [3:0] LEN_COMMISSION = 4'd7;
  localparam logic [3:0] LEN_STATUS = 4'd2;
  localparam logic [3:0] LEN_RELAY = 4'd1;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       relay_valid;
    logic [3:0] relay_value;
    logic       relay_power_up;
    logic       sleep_request;
    logic       restart_idle_timer;
    logic       commissioned;
  } lsfh_result_t;

  // standard LIN parity: P0 = ID0^ID1^ID2^ID4, P1 = ~(ID1^ID3^ID4^ID5)
  function automatic logic [7:0] protect(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  // 8-bit add with end-around carry
  function automatic logic [7:0] carry_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[7:0] + {7'd0, t[8]};
  endfunction

  localparam logic [7:0] PID_COMMISSION = protect(ID_COMMISSION);
  localparam logic [7:0] PID_ALL_SWITCHES = protect(ID_ALL_SWITCHES);
  localparam logic [7:0] PID_DIAG = protect(ID_DIAG);

endpackage

// ----- hw/rtl/lsfh_in_if.sv -----
interface lsfh_in_if;
  import lsfh_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;
  logic [3:0] switch_levels;

  modport source (output valid, output action, output rx_byte, output switch_levels,
                  input ready);
  modport sink (input valid, input action, input rx_byte, input switch_levels,
                output ready);
endinterface

// ----- hw/rtl/lsfh_out_if.sv -----
interface lsfh_out_if;
  import lsfh_pkg::*;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       relay_valid;
  logic [3:0] relay_value;
  logic       relay_power_up;
  logic       sleep_request;
  logic       restart_idle_timer;
  logic       commissioned;

  modport source (output valid, output tx_valid, output tx_byte, output relay_valid,
                  output relay_value, output relay_power_up, output sleep_request,
                  output restart_idle_timer, output commissioned, input ready);
  modport sink (input valid, input tx_valid, input tx_byte, input relay_valid,
                input relay_value, input relay_power_up, input sleep_request,
                input restart_idle_timer, input commissioned, output ready);
endinterface

// ----- hw/rtl/lsfh_frame_engine.sv -----
module lsfh_frame_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [1:0]            action,
  input  logic [7:0]            rx_byte,
  input  logic [3:0]            switch_levels,
  input  logic [31:0]           node_identity,
  output lsfh_pkg::lsfh_result_t result
);
  import lsfh_pkg::*;

  logic [2:0] frame_phase, frame_phase_next;
  logic [7:0] frame_pid, frame_pid_next;
  logic [3:0] byte_index, byte_index_next;
  logic [3:0] frame_length, frame_length_next;
  logic [7:0] running_sum, running_sum_next;
  logic [5:0] switch_frame_id, switch_frame_id_next;
  logic [5:0] relay_frame_id, relay_frame_id_next;
  byte_t      data_buffer [BufferBytes];
  byte_t      data_buffer_next [BufferBytes];

  logic [7:0]  pid_sw;
  logic [7:0]  pid_rel;
  logic [3:0]  idx_inc;
  logic [31:0] got_id;
  byte_t       echo_ref;

  assign pid_sw  = protect(switch_frame_id);
  assign pid_rel = protect(relay_frame_id);
  assign idx_inc = byte_index + 4'd1;
  assign got_id  = {data_buffer[3], data_buffer[2], data_buffer[1], data_buffer[0]};
  // status frame only ever indexes entries 0 and 1
  assign echo_ref = byte_index[0] ? data_buffer[1] : data_buffer[0];

  always_comb begin
    frame_phase_next     = frame_phase;
    frame_pid_next       = frame_pid;
    byte_index_next      = byte_index;
    frame_length_next    = frame_length;
    running_sum_next     = running_sum;
    switch_frame_id_next = switch_frame_id;
    relay_frame_id_next  = relay_frame_id;
    data_buffer_next     = data_buffer;
    result               = '0;

    case (action)
      ACT_BREAK: begin
        result.restart_idle_timer = 1'b1;
        frame_phase_next = PH_SYNC;
      end
      ACT_TIMEOUT: begin
        frame_phase_next = PH_IDLE;
      end
      ACT_BYTE: begin
        case (frame_phase)
          PH_SYNC: begin
            frame_phase_next = (rx_byte == SYNC_BYTE) ? PH_ID : PH_IDLE;
          end
          PH_ID: begin
            frame_pid_next   = rx_byte;
            byte_index_next  = 4'd0;
            running_sum_next = rx_byte;
            if (rx_byte == PID_COMMISSION) begin
              frame_length_next = LEN_COMMISSION;
              result.relay_power_up = 1'b1;
              frame_phase_next = PH_RECEIVE;
            end else if (rx_byte == PID_ALL_SWITCHES || rx_byte == pid_sw) begin
              data_buffer_next[0] = pid_sw;
              data_buffer_next[1] = {4'd0, switch_levels};
              frame_length_next = LEN_STATUS;
              running_sum_next = carry_add(rx_byte, pid_sw);
              result.tx_valid = 1'b1;
              result.tx_byte  = pid_sw;
              frame_phase_next = PH_SEND;
            end else if (rx_byte == pid_rel || rx_byte == PID_DIAG) begin
              frame_length_next = LEN_RELAY;
              result.relay_power_up = 1'b1;
              frame_phase_next = PH_RECEIVE;
            end else begin
              frame_phase_next = PH_IDLE;
            end
          end
          PH_RECEIVE: begin
            if (byte_index < frame_length) begin
              data_buffer_next[byte_index[BufIdxW-1:0]] = rx_byte;
              running_sum_next = carry_add(running_sum, rx_byte);
              byte_index_next = idx_inc;
            end else begin
              frame_phase_next = PH_IDLE;
              if (rx_byte == ~running_sum) begin
                if (frame_pid == PID_DIAG) begin
                  result.sleep_request = (data_buffer[0] == 8'd0);
                end else if (frame_pid == PID_COMMISSION) begin
                  if (got_id == node_identity) begin
                    result.commissioned = 1'b1;
                    if (data_buffer[4] >= {2'b00, ID_MIN} && data_buffer[4] < {2'b00, ID_DIAG})
                      switch_frame_id_next = data_buffer[4][5:0];
                    if (data_buffer[5] >= {2'b00, ID_MIN} && data_buffer[5] < {2'b00, ID_DIAG})
                      relay_frame_id_next = data_buffer[5][5:0];
                    result.relay_valid = 1'b1;
                    result.relay_value = data_buffer[6][3:0];
                  end
                end else if (frame_pid == pid_rel) begin
                  result.relay_valid = 1'b1;
                  result.relay_value = data_buffer[0][3:0];
                end
              end
            end
          end
          PH_SEND: begin
            if (rx_byte != echo_ref) begin
              frame_phase_next = PH_IDLE;
            end else begin
              byte_index_next = idx_inc;
              result.tx_valid = 1'b1;
              if (idx_inc < frame_length) begin
                // only the switch levels byte follows the first
                result.tx_byte = data_buffer[1];
                running_sum_next = carry_add(running_sum, data_buffer[1]);
              end else begin
                result.tx_byte = ~running_sum;
                frame_phase_next = PH_IDLE;
              end
            end
          end
          default: begin
            frame_phase_next = PH_IDLE;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase     <= PH_IDLE;
      frame_pid       <= 8'd0;
      byte_index      <= 4'd0;
      frame_length    <= 4'd0;
      running_sum     <= 8'd0;
      switch_frame_id <= ID_SWITCH_RESET;
      relay_frame_id  <= ID_RELAY_RESET;
    end else if (step) begin
      frame_phase     <= frame_phase_next;
      frame_pid       <= frame_pid_next;
      byte_index      <= byte_index_next;
      frame_length    <= frame_length_next;
      running_sum     <= running_sum_next;
      switch_frame_id <= switch_frame_id_next;
      relay_frame_id  <= relay_frame_id_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      data_buffer <= data_buffer_next;
    end
  end

endmodule

// ----- hw/rtl/lsfh_out_reg.sv -----
module lsfh_out_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  lsfh_pkg::lsfh_result_t result,
  output logic                   can_load,
  lsfh_out_if.source             rsp
);
  import lsfh_pkg::*;

  logic         valid;
  lsfh_result_t data;

  assign can_load = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= load || (valid && !rsp.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= result;
    end
  end

  assign rsp.valid              = valid;
  assign rsp.tx_valid           = data.tx_valid;
  assign rsp.tx_byte            = data.tx_byte;
  assign rsp.relay_valid        = data.relay_valid;
  assign rsp.relay_value        = data.relay_value;
  assign rsp.relay_power_up     = data.relay_power_up;
  assign rsp.sleep_request      = data.sleep_request;
  assign rsp.restart_idle_timer = data.restart_idle_timer;
  assign rsp.commissioned       = data.commissioned;

endmodule

// ----- hw/rtl/lin_slave_frame_handler_core.sv -----
// An accepted item enters the input register; its result is registered in the result register.
// Throughput: one item per cycle unless rsp stalls; the whole frame step is one pass of logic
//   between the input register and the result register.
// Reset (rst, synchronous, active high): frame phase idle, counters and sum zero,
//   switch id 3, relay id 4, node identity 0x19f0743e, both registers empty.
module lin_slave_frame_handler_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  lsfh_in_if.sink     req,
  lsfh_out_if.source  rsp
);
  import lsfh_pkg::*;

  // node identity register; the user must write it only while the handler is idle (not enforced here)
  logic [31:0] node_identity;

  // input register
  logic       in_valid;
  logic [1:0] in_action;
  logic [7:0] in_rx_byte;
  logic [3:0] in_switch_levels;

  logic         step;
  logic         can_load;
  lsfh_result_t result;

  // the held item is processed as soon as the result register can take it;
  // the input register refills in the same cycle
  assign step      = in_valid && can_load;
  assign req.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_identity <= NODE_IDENTITY_RESET;
    end else if (cfg_we) begin
      node_identity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_action        <= req.action;
      in_rx_byte       <= req.rx_byte;
      in_switch_levels <= req.switch_levels;
    end
  end

  // frame state machine, checksum and id tables
  lsfh_frame_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .action        (in_action),
    .rx_byte       (in_rx_byte),
    .switch_levels (in_switch_levels),
    .node_identity (node_identity),
    .result        (result)
  );

  // result register, decouples rsp stalls from the input side
  lsfh_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step),
    .result   (result),
    .can_load (can_load),
    .rsp      (rsp)
  );

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
  import lsfh_pkg::*;

  // action code 3 is not used by the bus; the block must leave it alone
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // cycles left after the last result before config writes or the end
  localparam int DRAIN_CYCLES = 4;
  // watchdog limit, in clock cycles
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_data;

  lsfh_in_if  req_if ();
  lsfh_out_if rsp_if ();

  lin_slave_frame_handler_core u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_if),
    .rsp      (rsp_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Frame handler mirror: phase, PID, index, length, running sum, buffer,
  // the two assignable frame ids and the node identity register.
  // ---------------------------------------------------------------------
  logic [2:0]  fr_phase;
  byte_t       fr_pid;
  logic [3:0]  fr_index;
  logic [3:0]  fr_length;
  byte_t       fr_sum;
  byte_t       frame_bytes [0:7];
  logic [5:0]  sw_id;
  logic [5:0]  relay_id;
  logic [31:0] node_id;

  // results predicted per accepted item, oldest first
  lsfh_result_t expected_results [$];
  lsfh_result_t checker_want;

  // bytes after the PID of the frame being built (data + checksum, or echoes)
  byte_t frame_body [0:8];

  int in_idle_pct;
  int out_idle_pct;
  int mismatch_count;
  int cycle_count;
  int effective_items;
  int frame_count;
  int n_relay_cmds;
  int n_commissions;
  int n_sleeps;
  int n_tx_bytes;

  // LIN protected id: P0 = even parity of ID0,1,2,4, P1 = odd parity of ID1,3,4,5
  function automatic byte_t lin_pid(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = ^{id[4], id[2], id[1], id[0]};
    p1 = ~^{id[5], id[4], id[3], id[1]};
    return {p1, p0, id};
  endfunction

  // 8-bit sum, carry folded back into bit 0
  function automatic byte_t sum_wrap(input byte_t a, input byte_t b);
    logic [8:0] s;
    s = a + b;
    return s[8] ? s[7:0] + 8'd1 : s[7:0];
  endfunction

  // enhanced checksum over the PID and the first n body bytes
  function automatic byte_t frame_check(input byte_t pid, input int n);
    byte_t s;
    int    k;
    s = pid;
    for (k = 0; k < n; k++) s = sum_wrap(s, frame_body[k]);
    return ~s;
  endfunction

  // Advance the mirror by one bus event and return the result it causes.
  function automatic lsfh_result_t predict_result(input logic [1:0] act, input byte_t rx,
                                                  input logic [3:0] lv);
    lsfh_result_t r;
    byte_t        p_comm;
    byte_t        p_all;
    byte_t        p_sw;
    byte_t        p_rel;
    byte_t        p_diag;
    logic [31:0]  got;
    r = '0;
    p_comm = lin_pid(ID_COMMISSION);
    p_all  = lin_pid(ID_ALL_SWITCHES);
    p_sw   = lin_pid(sw_id);
    p_rel  = lin_pid(relay_id);
    p_diag = lin_pid(ID_DIAG);
    case (act)
      ACT_BREAK: begin
        r.restart_idle_timer = 1'b1;
        fr_phase = PH_SYNC;
      end
      ACT_TIMEOUT: fr_phase = PH_IDLE;
      ACT_BYTE: begin
        case (fr_phase)
          PH_SYNC: fr_phase = (rx == SYNC_BYTE) ? PH_ID : PH_IDLE;
          PH_ID: begin
            fr_pid = rx;
            fr_index = '0;
            fr_sum = rx;
            // priority: commission, then switch frames, then relay / diag
            if (rx == p_comm) begin
              fr_length = LEN_COMMISSION;
              r.relay_power_up = 1'b1;
              fr_phase = PH_RECEIVE;
            end else if (rx == p_all || rx == p_sw) begin
              frame_bytes[0] = p_sw;
              frame_bytes[1] = {4'd0, lv};
              fr_length = LEN_STATUS;
              fr_sum = sum_wrap(fr_sum, p_sw);
              r.tx_valid = 1'b1;
              r.tx_byte = p_sw;
              fr_phase = PH_SEND;
            end else if (rx == p_rel || rx == p_diag) begin
              fr_length = LEN_RELAY;
              r.relay_power_up = 1'b1;
              fr_phase = PH_RECEIVE;
            end else begin
              fr_phase = PH_IDLE;
            end
          end
          PH_RECEIVE: begin
            if (fr_index < fr_length) begin
              frame_bytes[fr_index[2:0]] = rx;
              fr_sum = sum_wrap(fr_sum, rx);
              fr_index = fr_index + 4'd1;
            end else begin
              // checksum byte: bad checksum drops the frame silently
              fr_phase = PH_IDLE;
              if (rx == ~fr_sum) begin
                if (fr_pid == p_diag) begin
                  r.sleep_request = (frame_bytes[0] == 8'd0);
                end else if (fr_pid == p_comm) begin
                  got = {frame_bytes[3], frame_bytes[2], frame_bytes[1], frame_bytes[0]};
                  if (got == node_id) begin
                    r.commissioned = 1'b1;
                    // new ids only taken inside 4..59
                    if (frame_bytes[4] >= ID_MIN && frame_bytes[4] < ID_DIAG)
                      sw_id = frame_bytes[4][5:0];
                    if (frame_bytes[5] >= ID_MIN && frame_bytes[5] < ID_DIAG)
                      relay_id = frame_bytes[5][5:0];
                    r.relay_valid = 1'b1;
                    r.relay_value = frame_bytes[6][3:0];
                  end
                end else if (fr_pid == p_rel) begin
                  r.relay_valid = 1'b1;
                  r.relay_value = frame_bytes[0][3:0];
                end
              end
            end
          end
          PH_SEND: begin
            // each echo must match what was sent; checksum echo is not checked
            if (rx != frame_bytes[fr_index[2:0]]) begin
              fr_phase = PH_IDLE;
            end else begin
              fr_index = fr_index + 4'd1;
              r.tx_valid = 1'b1;
              if (fr_index < fr_length) begin
                r.tx_byte = frame_bytes[fr_index[2:0]];
                fr_sum = sum_wrap(fr_sum, r.tx_byte);
              end else begin
                r.tx_byte = ~fr_sum;
                fr_phase = PH_IDLE;
              end
            end
          end
          default: fr_phase = PH_IDLE;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus side
  // ---------------------------------------------------------------------

  // One item on req: random gap first, then hold until the handshake.
  task automatic send_item(input logic [1:0] act, input byte_t rx, input logic [3:0] lv);
    lsfh_result_t want;
    while ($urandom_range(99) < in_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.action        <= act;
    req_if.rx_byte       <= rx;
    req_if.switch_levels <= lv;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    // bytes in idle and the unused code do nothing, so they are not counted
    if (act == ACT_BREAK || act == ACT_TIMEOUT ||
        (act == ACT_BYTE && fr_phase >= PH_SYNC && fr_phase <= PH_SEND))
      effective_items++;
    want = predict_result(act, rx, lv);
    expected_results.push_back(want);
    if (want.relay_valid) n_relay_cmds++;
    if (want.commissioned) n_commissions++;
    if (want.sleep_request) n_sleeps++;
    if (want.tx_valid) n_tx_bytes++;
  endtask

  task automatic send_byte(input byte_t rx);
    send_item(ACT_BYTE, rx, 4'($urandom_range(15)));
  endtask

  task automatic frame_head(input byte_t pid, input logic [3:0] lv);
    send_item(ACT_BREAK, 8'($urandom_range(255)), 4'($urandom_range(15)));
    send_byte(SYNC_BYTE);
    send_item(ACT_BYTE, pid, lv);
  endtask

  // fault: 0 clean, 1 one bit flipped in the body, 2 cut short by timeout or break
  task automatic send_frame(input byte_t pid, input logic [3:0] lv, input int n,
                            input int fault);
    int cut;
    int k;
    int pos;
    cut = n;
    if (fault == 1) begin
      pos = $urandom_range(n - 1);
      frame_body[pos] = frame_body[pos] ^ (8'd1 << $urandom_range(7));
    end
    if (fault == 2) cut = $urandom_range(n - 1);
    frame_count++;
    frame_head(pid, lv);
    for (k = 0; k < cut; k++) send_byte(frame_body[k]);
    if (fault == 2) begin
      if ($urandom_range(1))
        send_item(ACT_TIMEOUT, 8'($urandom_range(255)), 4'($urandom_range(15)));
      else
        send_item(ACT_BREAK, 8'($urandom_range(255)), 4'($urandom_range(15)));
    end
  endtask

  // status read: echoes of the PID and the levels, then the checksum echo
  task automatic status_frame(input bit all_ids, input logic [3:0] lv, input int fault);
    byte_t pid;
    pid = all_ids ? lin_pid(ID_ALL_SWITCHES) : lin_pid(sw_id);
    frame_body[0] = lin_pid(sw_id);
    frame_body[1] = {4'd0, lv};
    frame_body[2] = frame_check(pid, 2);
    send_frame(pid, lv, 3, fault);
  endtask

  task automatic relay_frame(input byte_t value, input int fault);
    byte_t pid;
    pid = lin_pid(relay_id);
    frame_body[0] = value;
    frame_body[1] = frame_check(pid, 1);
    send_frame(pid, 4'($urandom_range(15)), 2, fault);
  endtask

  task automatic diag_frame(input byte_t first, input int fault);
    byte_t pid;
    pid = lin_pid(ID_DIAG);
    frame_body[0] = first;
    frame_body[1] = frame_check(pid, 1);
    send_frame(pid, 4'($urandom_range(15)), 2, fault);
  endtask

  // identity LSB first, then new switch id, new relay id, relay byte
  task automatic commission_frame(input logic [31:0] ident, input byte_t new_sw,
                                  input byte_t new_rel, input byte_t relay, input int fault);
    byte_t pid;
    pid = lin_pid(ID_COMMISSION);
    frame_body[0] = ident[7:0];
    frame_body[1] = ident[15:8];
    frame_body[2] = ident[23:16];
    frame_body[3] = ident[31:24];
    frame_body[4] = new_sw;
    frame_body[5] = new_rel;
    frame_body[6] = relay;
    frame_body[7] = frame_check(pid, 7);
    send_frame(pid, 4'($urandom_range(15)), 8, fault);
  endtask

  // mostly legal ids, some at the edges just outside, some anything
  function automatic byte_t pick_new_id();
    int sel;
    sel = $urandom_range(9);
    if (sel < 7) return 8'($urandom_range(ID_DIAG - 1, ID_MIN));
    if (sel == 7) return $urandom_range(1) ? 8'(ID_MIN - 1) : 8'(ID_DIAG);
    return 8'($urandom_range(255));
  endfunction

  // lower valid, wait for every result, then let the pipe settle
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // only called with nothing in flight
  task automatic write_identity(input logic [31:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    node_id = value;
  endtask

  // Mixed traffic: mostly whole frames with random content, some broken
  // or cut short, the rest loose events and bad headers.
  task automatic run_random(input int target);
    int          stop_at;
    int          pick;
    int          fault;
    logic [31:0] ident;
    stop_at = effective_items + target;
    while (effective_items < stop_at) begin
      pick  = $urandom_range(99);
      fault = $urandom_range(99);
      fault = (fault < 80) ? 0 : (fault < 90) ? 1 : 2;
      if (pick < 22) begin
        status_frame(1'($urandom_range(1)), 4'($urandom_range(15)), fault);
      end else if (pick < 40) begin
        relay_frame(8'($urandom_range(255)), fault);
      end else if (pick < 55) begin
        // usually our identity, sometimes one bit off, sometimes anything
        ident = node_id;
        if ($urandom_range(99) < 15) ident = ident ^ (32'd1 << $urandom_range(31));
        else if ($urandom_range(99) < 10) ident = $urandom;
        commission_frame(ident, pick_new_id(), pick_new_id(), 8'($urandom_range(255)),
                         fault);
      end else if (pick < 65) begin
        diag_frame($urandom_range(1) ? 8'd0 : 8'($urandom_range(255)), fault);
      end else if (pick < 80) begin
        send_item(2'($urandom_range(3)), 8'($urandom_range(255)), 4'($urandom_range(15)));
      end else if (pick < 90) begin
        // header with a sync byte that is usually wrong
        send_item(ACT_BREAK, 8'($urandom_range(255)), 4'($urandom_range(15)));
        send_byte($urandom_range(3) == 0 ? SYNC_BYTE : 8'($urandom_range(255)));
      end else begin
        // header with a random PID, mostly unknown
        send_item(ACT_BREAK, 8'($urandom_range(255)), 4'($urandom_range(15)));
        send_byte(SYNC_BYTE);
        send_item(ACT_BYTE, 8'($urandom_range(255)), 4'($urandom_range(15)));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // loose events: byte in idle, unused code, timeout, bad sync, unknown PID
  task automatic test_bus_events();
    send_byte(8'hff);
    send_item(ACT_UNUSED, 8'h00, 4'h0);
    send_item(ACT_TIMEOUT, 8'hff, 4'hf);
    send_item(ACT_BREAK, 8'h00, 4'h0);
    send_byte(8'h00);
    send_item(ACT_BREAK, 8'hff, 4'hf);
    send_byte(SYNC_BYTE);
    send_byte(8'h00);
  endtask

  // reset identity, both new ids at the ends of the legal range
  task automatic test_commission();
    commission_frame(NODE_IDENTITY_RESET, 8'(ID_DIAG - 1), 8'(ID_MIN), 8'hff, 0);
  endtask

  // all-switches PID with every switch active
  task automatic test_status();
    status_frame(1'b1, 4'hf, 0);
  endtask

  task automatic test_relay();
    relay_frame(8'h00, 0);
  endtask

  // first byte zero asks for sleep
  task automatic test_diag();
    diag_frame(8'h00, 0);
  endtask

  // three idle settings, a new identity before each, extremes included
  task automatic test_random_traffic();
    in_idle_pct = 35;
    out_idle_pct = 71;
    write_identity($urandom);
    run_random(600);
    wait_drained();
    in_idle_pct = 71;
    out_idle_pct = 35;
    write_identity('1);
    run_random(600);
    wait_drained();
    in_idle_pct = 0;
    out_idle_pct = 0;
    write_identity('0);
    run_random(550);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------
  // Result side: random back-pressure and in-order compare
  // ---------------------------------------------------------------------
  always @(posedge clk) rsp_if.ready <= ($urandom_range(99) >= out_idle_pct);

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, actual tx %0h/%0h",
                 $time, rsp_if.tx_valid, rsp_if.tx_byte);
        mismatch_count++;
      end else begin
        checker_want = expected_results.pop_front();
        check_field("tx_valid", 8'(checker_want.tx_valid), 8'(rsp_if.tx_valid));
        check_field("tx_byte", checker_want.tx_byte, rsp_if.tx_byte);
        check_field("relay_valid", 8'(checker_want.relay_valid), 8'(rsp_if.relay_valid));
        check_field("relay_value", 8'(checker_want.relay_value), 8'(rsp_if.relay_value));
        check_field("relay_power_up", 8'(checker_want.relay_power_up),
                    8'(rsp_if.relay_power_up));
        check_field("sleep_request", 8'(checker_want.sleep_request),
                    8'(rsp_if.sleep_request));
        check_field("restart_idle_timer", 8'(checker_want.restart_idle_timer),
                    8'(rsp_if.restart_idle_timer));
        check_field("commissioned", 8'(checker_want.commissioned), 8'(rsp_if.commissioned));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.action = ACT_BREAK;
    req_if.rx_byte = '0;
    req_if.switch_levels = '0;
    rsp_if.ready = 1'b0;
    cycle_count = 0;
    mismatch_count = 0;
    effective_items = 0;
    frame_count = 0;
    n_relay_cmds = 0;
    n_commissions = 0;
    n_sleeps = 0;
    n_tx_bytes = 0;
    in_idle_pct = 35;
    out_idle_pct = 71;
    // mirror starts from the reset state
    fr_phase = PH_IDLE;
    fr_pid = '0;
    fr_index = '0;
    fr_length = '0;
    fr_sum = '0;
    for (int k = 0; k < 8; k++) frame_bytes[k] = '0;
    sw_id = ID_SWITCH_RESET;
    relay_id = ID_RELAY_RESET;
    node_id = NODE_IDENTITY_RESET;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_bus_events();
    test_commission();
    test_status();
    test_relay();
    test_diag();
    wait_drained();
    test_random_traffic();

    $display("summary: %0d counted items in %0d frames, %0d transmitted bytes",
             effective_items, frame_count, n_tx_bytes);
    $display("summary: %0d relay commands, %0d commissions, %0d sleep requests, %0d errors",
             n_relay_cmds, n_commissions, n_sleeps, mismatch_count);
    if (mismatch_count == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
